// ===== rtl/sse_pkg.sv =====
// Shared types and constants for the surface sense evaluator.
package sse_pkg;

   localparam int unsigned FIX_W    = 32;  // Q16.16 operand width
   localparam int unsigned OFF_W    = 33;  // difference of two Q16.16 values
   localparam int unsigned PROD_W   = 66;  // exact product of two offsets
   localparam int unsigned SUM_W    = 68;  // sum of four products, never overflows
   localparam int unsigned THRESH_W = 63;

   localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(4295);
   localparam logic signed [OFF_W-1:0] Q_ONE = OFF_W'(65536);

   typedef enum logic [3:0] {
      KIND_P   = 4'd0,
      KIND_PX  = 4'd1,
      KIND_PY  = 4'd2,
      KIND_PZ  = 4'd3,
      KIND_SO  = 4'd4,
      KIND_S   = 4'd5,
      KIND_SX  = 4'd6,
      KIND_SY  = 4'd7,
      KIND_SZ  = 4'd8,
      KIND_C_X = 4'd9,
      KIND_C_Y = 4'd10,
      KIND_C_Z = 4'd11,
      KIND_CX  = 4'd12,
      KIND_CY  = 4'd13,
      KIND_CZ  = 4'd14
   } kind_type;

   typedef logic signed [OFF_W-1:0]  off_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

endpackage

// ===== rtl/surface_sense_evaluator.sv =====
// Quadric surface sense test: which side of a surface a point lies on.
//
// Input channel (req_*): one transaction carries a surface kind, four Q16.16
// surface parameters, a Q16.16 position and a Q16.16 direction. It is taken
// at a clock edge where req_valid is high and req_stall is low.
// Result channel (rsp_*): one transaction per input, in order, carrying
// rsp_positive_side (1 = sense +1, 0 = sense -1).
// csr_wr_en / csr_wr_data load the Q32.32 near-zero threshold; write it only
// while no transaction is in flight.
//
// Three register stages: input register, product register (seven parallel
// 33x33 multipliers), result register. While rsp_stall is low, throughput is
// one transaction per cycle, set by the single multiplier bank and the 68-bit
// sum/compare in the last stage.
// Reset clears all valid bits and loads the threshold reset value.
// When rsp_stall holds a result, earlier stages keep filling their empty
// slots; req_stall rises only when every stage holds a transaction.
module surface_sense_evaluator
   import sse_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [62:0]         csr_wr_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [3:0]          req_surface_kind,
   input  logic signed [31:0]  req_coef_a,
   input  logic signed [31:0]  req_coef_b,
   input  logic signed [31:0]  req_coef_c,
   input  logic signed [31:0]  req_coef_d,
   input  logic signed [31:0]  req_pos_x,
   input  logic signed [31:0]  req_pos_y,
   input  logic signed [31:0]  req_pos_z,
   input  logic signed [31:0]  req_dir_x,
   input  logic signed [31:0]  req_dir_y,
   input  logic signed [31:0]  req_dir_z,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_positive_side
);

   function automatic prod_type mul_off(off_type x, off_type y);
      prod_type xe;
      prod_type ye;
      xe = PROD_W'(x);
      ye = PROD_W'(y);
      return xe * ye;
   endfunction

   function automatic off_type ext(logic signed [FIX_W-1:0] v);
      return OFF_W'(v);
   endfunction

   // threshold register
   logic [THRESH_W-1:0] thresh_ff, thresh_in;

   // stage A: input register
   logic                    a_valid_ff, a_valid_in;
   logic [3:0]              a_kind_ff;
   logic signed [FIX_W-1:0] a_coef_ff [4];
   logic signed [FIX_W-1:0] a_pos_ff  [3];
   logic signed [FIX_W-1:0] a_dir_ff  [3];

   // stage B: products
   logic     b_valid_ff, b_valid_in;
   prod_type b_val_ff [3];
   prod_type b_dot_ff [3];
   prod_type b_k_ff;

   // stage C: result
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_side_ff, rsp_side_in;

   logic c_move, b_load, a_load;

   assign c_move    = !rsp_valid_ff || !rsp_stall;
   assign b_load    = !b_valid_ff || c_move;
   assign a_load    = !a_valid_ff || b_load;
   assign req_stall = !a_load;

   assign a_valid_in   = a_load ? req_valid : a_valid_ff;
   assign b_valid_in   = b_load ? a_valid_ff : b_valid_ff;
   assign rsp_valid_in = c_move ? b_valid_ff : rsp_valid_ff;
   assign thresh_in    = csr_wr_en ? csr_wr_data : thresh_ff;

   // operand selection: val = sum(fa*fb) - ka*kb, dot = sum(dir*ga)
   off_type fa [3];
   off_type fb [3];
   off_type ga [3];
   off_type ka, kb;
   off_type ctr [3];
   off_type rad;
   logic    use_ax [3];
   logic    quad;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fa[i]     = '0;
         fb[i]     = '0;
         ga[i]     = '0;
         ctr[i]    = '0;
         use_ax[i] = 1'b1;
      end
      ka   = '0;
      kb   = '0;
      rad  = '0;
      quad = 1'b0;
      unique case (kind_type'(a_kind_ff))
         KIND_P: begin
            for (int i = 0; i < 3; i++) begin
               fa[i] = ext(a_coef_ff[i]);
               fb[i] = ext(a_pos_ff[i]);
               ga[i] = ext(a_coef_ff[i]);
            end
            ka = ext(a_coef_ff[3]);
            kb = Q_ONE;
         end
         KIND_PX, KIND_PY, KIND_PZ: begin
            for (int i = 0; i < 3; i++) begin
               if (a_kind_ff == 4'(KIND_PX) + 4'(i)) begin
                  fa[i] = ext(a_pos_ff[i]) - ext(a_coef_ff[0]);
                  fb[i] = Q_ONE;
                  ga[i] = Q_ONE;
               end
            end
         end
         KIND_SO: begin
            quad = 1'b1;
            rad  = ext(a_coef_ff[0]);
         end
         KIND_S: begin
            quad = 1'b1;
            for (int i = 0; i < 3; i++) ctr[i] = ext(a_coef_ff[i]);
            rad = ext(a_coef_ff[3]);
         end
         KIND_SX, KIND_SY, KIND_SZ: begin
            quad = 1'b1;
            for (int i = 0; i < 3; i++) begin
               if (a_kind_ff == 4'(KIND_SX) + 4'(i)) ctr[i] = ext(a_coef_ff[0]);
            end
            rad = ext(a_coef_ff[1]);
         end
         KIND_C_X: begin
            quad      = 1'b1;
            use_ax[0] = 1'b0;
            ctr[1]    = ext(a_coef_ff[0]);
            ctr[2]    = ext(a_coef_ff[1]);
            rad       = ext(a_coef_ff[2]);
         end
         KIND_C_Y: begin
            quad      = 1'b1;
            use_ax[1] = 1'b0;
            ctr[0]    = ext(a_coef_ff[0]);
            ctr[2]    = ext(a_coef_ff[1]);
            rad       = ext(a_coef_ff[2]);
         end
         KIND_C_Z: begin
            quad      = 1'b1;
            use_ax[2] = 1'b0;
            ctr[0]    = ext(a_coef_ff[0]);
            ctr[1]    = ext(a_coef_ff[1]);
            rad       = ext(a_coef_ff[2]);
         end
         KIND_CX, KIND_CY, KIND_CZ: begin
            quad = 1'b1;
            for (int i = 0; i < 3; i++) begin
               if (a_kind_ff == 4'(KIND_CX) + 4'(i)) use_ax[i] = 1'b0;
            end
            rad = ext(a_coef_ff[0]);
         end
         default: begin
            // unused code: everything stays zero, side comes out negative
         end
      endcase
      if (quad) begin
         ka = rad;
         kb = rad;
         for (int i = 0; i < 3; i++) begin
            if (use_ax[i]) begin
               fa[i] = ext(a_pos_ff[i]) - ctr[i];
               fb[i] = fa[i];
               ga[i] = fa[i];
            end
         end
      end
   end

   // final sums and on-surface fallback
   sum_type val_sum, dot_sum, val_abs;
   logic    near_zero;

   always_comb begin
      val_sum = -SUM_W'(b_k_ff);
      dot_sum = '0;
      for (int i = 0; i < 3; i++) begin
         val_sum = val_sum + SUM_W'(b_val_ff[i]);
         dot_sum = dot_sum + SUM_W'(b_dot_ff[i]);
      end
      val_abs   = val_sum[SUM_W-1] ? -val_sum : val_sum;
      near_zero = val_abs < sum_type'({{(SUM_W-THRESH_W){1'b0}}, thresh_ff});
      rsp_side_in = near_zero ? (dot_sum > 0) : (val_sum > 0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff    <= THRESH_RESET;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         thresh_ff    <= thresh_in;
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_kind_ff    <= req_surface_kind;
         a_coef_ff[0] <= req_coef_a;
         a_coef_ff[1] <= req_coef_b;
         a_coef_ff[2] <= req_coef_c;
         a_coef_ff[3] <= req_coef_d;
         a_pos_ff[0]  <= req_pos_x;
         a_pos_ff[1]  <= req_pos_y;
         a_pos_ff[2]  <= req_pos_z;
         a_dir_ff[0]  <= req_dir_x;
         a_dir_ff[1]  <= req_dir_y;
         a_dir_ff[2]  <= req_dir_z;
      end
      if (b_load) begin
         for (int i = 0; i < 3; i++) begin
            b_val_ff[i] <= mul_off(fa[i], fb[i]);
            b_dot_ff[i] <= mul_off(ext(a_dir_ff[i]), ga[i]);
         end
         b_k_ff <= mul_off(ka, kb);
      end
      if (c_move) begin
         rsp_side_ff <= rsp_side_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_positive_side = rsp_side_ff;

endmodule

// ===== dv/surface_sense_evaluator_test.sv =====
// Self-checking testbench for the surface sense evaluator.
module surface_sense_evaluator_test
   import sse_pkg::*;
();

   localparam logic [3:0] KIND_UNUSED = 4'd15;
   localparam logic signed [31:0] MIN_FIX = 32'sh8000_0000;
   localparam logic signed [31:0] MAX_FIX = 32'sh7fff_ffff;
   localparam logic signed [31:0] ONE_FIX = 32'sd65536;
   localparam logic [62:0] THRESH_MAX = {63{1'b1}};

   typedef struct {
      logic [3:0]         kind;
      logic signed [31:0] coef_a;
      logic signed [31:0] coef_b;
      logic signed [31:0] coef_c;
      logic signed [31:0] coef_d;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
   } surface_query_type;

   class side_scoreboard;
      logic [62:0] threshold;
      bit side_q[$];
      int unsigned errors;

      function new();
         threshold = THRESH_RESET;
         errors = 0;
      endfunction

      // Exact Q32.32 surface value and normal dot product in 128 bits.
      function bit predict_side(surface_query_type q);
         logic signed [127:0] pt[3], dv[3], ctr[3];
         logic signed [127:0] a, b, c, d, rad, val, dot, off;
         logic [127:0] mag;
         bit used[3];
         int ax, j;
         a = q.coef_a;
         b = q.coef_b;
         c = q.coef_c;
         d = q.coef_d;
         pt[0] = q.pos_x;
         pt[1] = q.pos_y;
         pt[2] = q.pos_z;
         dv[0] = q.dir_x;
         dv[1] = q.dir_y;
         dv[2] = q.dir_z;
         val = 0;
         dot = 0;
         rad = 0;
         for (int i = 0; i < 3; i++) begin
            ctr[i] = 0;
            used[i] = 1'b1;
         end
         case (q.kind)
            KIND_P: begin
               val = a * pt[0] + b * pt[1] + c * pt[2] - d * Q_ONE;
               dot = dv[0] * a + dv[1] * b + dv[2] * c;
            end
            KIND_PX, KIND_PY, KIND_PZ: begin
               ax = q.kind - KIND_PX;
               val = (pt[ax] - a) * Q_ONE;
               dot = dv[ax] * Q_ONE;
            end
            KIND_UNUSED: ;
            default: begin
               case (q.kind)
                  KIND_SO: rad = a;
                  KIND_S: begin
                     ctr[0] = a;
                     ctr[1] = b;
                     ctr[2] = c;
                     rad = d;
                  end
                  KIND_SX, KIND_SY, KIND_SZ: begin
                     ctr[q.kind - KIND_SX] = a;
                     rad = b;
                  end
                  KIND_C_X, KIND_C_Y, KIND_C_Z: begin
                     used[q.kind - KIND_C_X] = 1'b0;
                     j = 0;
                     for (int i = 0; i < 3; i++) begin
                        if (used[i]) begin
                           ctr[i] = (j == 0) ? a : b;
                           j++;
                        end
                     end
                     rad = c;
                  end
                  default: begin
                     used[q.kind - KIND_CX] = 1'b0;
                     rad = a;
                  end
               endcase
               val = -(rad * rad);
               for (int i = 0; i < 3; i++) begin
                  if (used[i]) begin
                     off = pt[i] - ctr[i];
                     val += off * off;
                     dot += dv[i] * off;
                  end
               end
            end
         endcase
         mag = val[127] ? -val : val;
         if (mag < {65'd0, threshold}) val = dot;
         return val > 0;
      endfunction

      function void note_query(surface_query_type q);
         side_q.push_back(predict_side(q));
      endfunction

      function void check_side(logic actual);
         bit want;
         if (side_q.size() == 0) begin
            $error("positive_side: result with no transaction outstanding, actual %0d", actual);
            errors++;
            return;
         end
         want = side_q.pop_front();
         if (actual !== want) begin
            $error("positive_side: expected %0d, actual %0d", want, actual);
            errors++;
         end
      endfunction

      function int pending();
         return side_q.size();
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [62:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [3:0] req_surface_kind = '0;
   logic signed [31:0] req_coef_a = '0, req_coef_b = '0, req_coef_c = '0, req_coef_d = '0;
   logic signed [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [31:0] req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_positive_side;

   side_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_kick = 1'b0, kick_seen = 1'b0;
   int hold_len = 0, hold_left = 0;

   surface_sense_evaluator dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_surface_kind  (req_surface_kind),
      .req_coef_a        (req_coef_a),
      .req_coef_b        (req_coef_b),
      .req_coef_c        (req_coef_c),
      .req_coef_d        (req_coef_d),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pos_z         (req_pos_z),
      .req_dir_x         (req_dir_x),
      .req_dir_y         (req_dir_y),
      .req_dir_z         (req_dir_z),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_positive_side (rsp_positive_side)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("surface_sense_evaluator verification failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_query('{req_surface_kind, req_coef_a, req_coef_b, req_coef_c, req_coef_d,
                         req_pos_x, req_pos_y, req_pos_z, req_dir_x, req_dir_y, req_dir_z});
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_side(rsp_positive_side);
   end

   // Receiver: random stalls, plus a long hold-off when kicked.
   always @(posedge clock) begin
      if (hold_kick != kick_seen) begin
         kick_seen = hold_kick;
         hold_left = hold_len;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   function automatic logic signed [31:0] any_fix();
      case ($urandom_range(7))
         0: return '0;
         1: return MIN_FIX;
         2: return MAX_FIX;
         3: return int'($urandom_range(512)) - 256;
         default: return $urandom();
      endcase
   endfunction

   // Bounded coordinate, magnitude up to 2^20
   function automatic int near_fix();
      int mag;
      mag = int'($urandom() >> $urandom_range(12, 31));
      return $urandom_range(1) ? -mag : mag;
   endfunction

   function automatic int nudge();
      case ($urandom_range(3))
         0: return 0;
         1: return $urandom_range(1) ? -1 : 1;
         2: return int'($urandom_range(510)) - 255;
         default: return int'($urandom_range(131072)) - 65536;
      endcase
   endfunction

   function automatic surface_query_type random_query();
      surface_query_type q;
      q.kind = 4'($urandom_range(15));
      q.coef_a = any_fix();
      q.coef_b = any_fix();
      q.coef_c = any_fix();
      q.coef_d = any_fix();
      q.pos_x = any_fix();
      q.pos_y = any_fix();
      q.pos_z = any_fix();
      q.dir_x = any_fix();
      q.dir_y = any_fix();
      q.dir_z = any_fix();
      return q;
   endfunction

   // Point on or just off the surface, so the near-zero path and the
   // direction test get exercised.
   function automatic surface_query_type near_surface_query();
      surface_query_type q;
      int ctr[3], pos[3], k[3];
      int r, dlt, ax, j;
      bit used[3];
      q = random_query();
      q.kind = 4'($urandom_range(14));
      dlt = nudge();
      r = near_fix();
      for (int i = 0; i < 3; i++) begin
         ctr[i] = near_fix();
         used[i] = 1'b1;
         pos[i] = any_fix();
      end
      case (q.kind)
         KIND_P: begin
            for (int i = 0; i < 3; i++) begin
               k[i] = int'($urandom_range(64)) - 32;
               pos[i] = k[i] * 65536;
            end
            q.coef_a = ctr[0];
            q.coef_b = ctr[1];
            q.coef_c = ctr[2];
            q.coef_d = ctr[0] * k[0] + ctr[1] * k[1] + ctr[2] * k[2];
            ax = $urandom_range(2);
            pos[ax] += dlt;
         end
         KIND_PX, KIND_PY, KIND_PZ: begin
            ax = q.kind - KIND_PX;
            q.coef_a = ctr[0];
            pos[ax] = ctr[0] + dlt;
         end
         default: begin
            case (q.kind)
               KIND_SO, KIND_CX, KIND_CY, KIND_CZ: ctr = '{0, 0, 0};
               KIND_SX, KIND_SY, KIND_SZ: begin
                  for (int i = 0; i < 3; i++)
                     if (i != q.kind - KIND_SX) ctr[i] = 0;
               end
               default: ;
            endcase
            if (q.kind >= KIND_C_X && q.kind <= KIND_C_Z) used[q.kind - KIND_C_X] = 1'b0;
            if (q.kind >= KIND_CX) used[q.kind - KIND_CX] = 1'b0;
            do ax = $urandom_range(2); while (!used[ax]);
            for (int i = 0; i < 3; i++)
               if (used[i]) pos[i] = ctr[i];
            pos[ax] = ctr[ax] + r + dlt;
            case (q.kind)
               KIND_SO, KIND_CX, KIND_CY, KIND_CZ: q.coef_a = r;
               KIND_S: begin
                  q.coef_a = ctr[0];
                  q.coef_b = ctr[1];
                  q.coef_c = ctr[2];
                  q.coef_d = r;
               end
               KIND_SX, KIND_SY, KIND_SZ: begin
                  q.coef_a = ctr[q.kind - KIND_SX];
                  q.coef_b = r;
               end
               default: begin
                  j = 0;
                  for (int i = 0; i < 3; i++) begin
                     if (used[i]) begin
                        if (j == 0) q.coef_a = ctr[i];
                        else q.coef_b = ctr[i];
                        j++;
                     end
                  end
                  q.coef_c = r;
               end
            endcase
         end
      endcase
      q.pos_x = pos[0];
      q.pos_y = pos[1];
      q.pos_z = pos[2];
      if ($urandom_range(5) == 0) begin
         q.dir_x = '0;
         q.dir_y = '0;
         q.dir_z = '0;
      end
      return q;
   endfunction

   task automatic send_query(input surface_query_type q);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_surface_kind <= q.kind;
      req_coef_a <= q.coef_a;
      req_coef_b <= q.coef_b;
      req_coef_c <= q.coef_c;
      req_coef_d <= q.coef_d;
      req_pos_x <= q.pos_x;
      req_pos_y <= q.pos_y;
      req_pos_z <= q.pos_z;
      req_dir_x <= q.dir_x;
      req_dir_y <= q.dir_y;
      req_dir_z <= q.dir_z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [62:0] value);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.threshold = value;
   endtask

   task automatic run_phase(input logic [62:0] limit_value, input int idle_pct,
                            input int stall_pct, input int count, input bit squeeze);
      write_threshold(limit_value);
      send_idle_pct = idle_pct;
      recv_stall_pct <= stall_pct;
      if (squeeze) begin
         hold_len <= 64;
         hold_kick <= ~hold_kick;
      end
      repeat (count) begin
         if ($urandom_range(9) < 2) send_query(random_query());
         else send_query(near_surface_query());
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      surface_query_type q;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // every kind once, including the unused code, at the reset threshold
      for (int k = 0; k < 16; k++) begin
         q = random_query();
         q.kind = 4'(k);
         send_query(q);
      end
      send_query('{KIND_P, MAX_FIX, MAX_FIX, MAX_FIX, MAX_FIX, MAX_FIX, MAX_FIX, MAX_FIX,
                   MAX_FIX, MAX_FIX, MAX_FIX});
      send_query('{KIND_P, MIN_FIX, MIN_FIX, MIN_FIX, MIN_FIX, MIN_FIX, MIN_FIX, MIN_FIX,
                   MIN_FIX, MIN_FIX, MIN_FIX});
      // largest offsets in both directions
      send_query('{KIND_S, MIN_FIX, MIN_FIX, MIN_FIX, MIN_FIX, MAX_FIX, MAX_FIX, MAX_FIX,
                   ONE_FIX, ONE_FIX, ONE_FIX});
      send_query('{KIND_S, MAX_FIX, MAX_FIX, MAX_FIX, 0, MIN_FIX, MIN_FIX, MIN_FIX,
                   MIN_FIX, MIN_FIX, MIN_FIX});
      // on the surface with zero dot product
      send_query('{KIND_SO, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
      // on the surface, direction decides
      send_query('{KIND_PX, 5 * ONE_FIX, 0, 0, 0, 5 * ONE_FIX, 0, 0, 1, 0, 0});
      send_query('{KIND_PX, 5 * ONE_FIX, 0, 0, 0, 5 * ONE_FIX, 0, 0, -1, 0, 0});
      send_query('{KIND_PY, ONE_FIX, 0, 0, 0, 0, ONE_FIX, 0, 0, 0, 0});
      send_query('{KIND_CZ, ONE_FIX, 0, 0, 0, ONE_FIX, 0, MIN_FIX, -1, 0, MAX_FIX});
      send_query('{KIND_C_Y, ONE_FIX, -ONE_FIX, ONE_FIX, 0, 2 * ONE_FIX, MAX_FIX, -ONE_FIX,
                   1, 0, 0});
      req_valid <= 1'b0;

      run_phase('0, 0, 0, 155, 1'b1);
      run_phase(THRESH_MAX, 58, 0, 155, 1'b0);
      run_phase(63'd1 << 32, 0, 58, 155, 1'b0);
      run_phase(63'd1, 38, 38, 155, 1'b0);
      run_phase(63'({$urandom(), $urandom()} >> $urandom_range(1, 62)), 0, 0, 155, 1'b0);
      run_phase(63'($urandom_range(1 << 20)), 38, 38, 155, 1'b0);

      recv_stall_pct <= 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("surface_sense_evaluator verification clean");
      end else begin
         $display("surface_sense_evaluator verification failed");
      end
      $finish;
   end

endmodule
